// ----- hw/rtl/hierarchical_timing_wheel_assert.svh -----
// assertion macros for the hierarchical timing wheel
`ifndef HIERARCHICAL_TIMING_WHEEL_ASSERT_SVH
`define HIERARCHICAL_TIMING_WHEEL_ASSERT_SVH

// condition must hold in the same cycle
`define HTW_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition must hold in the next cycle
`define HTW_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/htw_pkg.sv -----
// shared types and constants of the hierarchical timing wheel
package htw_pkg;

   localparam int SLOT_W     = 6;
   localparam int REM_W      = 36;
   localparam int DELAY_W    = 36;
   localparam int TIME_W     = 44;
   localparam int SPAN_CAP_LOG = 40;

   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_START = 1'b1;

   typedef enum logic [1:0] {
      KIND_ACCEPTED = 2'd0,
      KIND_FULL     = 2'd1,
      KIND_EXPIRED  = 2'd2
   } kind_type;

   // log2 of the tick unit of a level, capped like the span
   function automatic logic [5:0] unit_shift(input int unsigned lv);
      int unsigned s;
      s = lv * SLOT_W;
      if (s > SPAN_CAP_LOG) begin
         s = SPAN_CAP_LOG;
      end
      return 6'(s);
   endfunction

endpackage

// ----- hw/rtl/hierarchical_timing_wheel.sv -----
// hierarchical timing wheel with a fixed timer pool held in ram
//
//  channel | direction | ports
//  --------+-----------+-----------------------------------------------
//  req     | in        | req_valid req_stall operation delay task msg
//  rsp     | out       | rsp_valid rsp_stall kind expired_* last
//
// one item at a time. a start searches the pool for a free entry, places the
// timer level by level and then reports accepted, or reports full if none is free.
// a tick reads, compares and steps each pool entry for each level it reaches
// (ram read, compare, step), and places each cascaded timer level by level.
// reset clears the wheel positions and the pool valid bits at once.
// req_stall is high whenever an item is in progress; rsp_stall holds results.
module hierarchical_timing_wheel #(
   parameter int NUM_LEVELS = 6,
   parameter int POOL_SIZE  = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [35:0] req_delay,
   input  logic [15:0] req_task_req,
   input  logic [15:0] req_msg_id,
   input  logic [31:0] req_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_expired_task,
   output logic [15:0] rsp_expired_id,
   output logic [31:0] rsp_expired_message,
   output logic        rsp_last
);

`include "hierarchical_timing_wheel_assert.svh"

   localparam int IW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
   localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
   localparam int SW = htw_pkg::SLOT_W;
   localparam int RW = htw_pkg::REM_W;
   localparam int TW = htw_pkg::TIME_W;
   localparam int WORD_W = LW + SW + RW + 64;
   localparam int FULL_SHIFT = (SW * NUM_LEVELS > htw_pkg::SPAN_CAP_LOG) ?
                               htw_pkg::SPAN_CAP_LOG : SW * NUM_LEVELS;
   localparam logic [40:0] FULL_SPAN = 41'(1) << FULL_SHIFT;
   localparam logic [IW-1:0] LAST_IDX = IW'(POOL_SIZE - 1);
   localparam logic [LW-1:0] TOP_LV = LW'(NUM_LEVELS - 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_FIND, ST_PLACE, ST_EMIT, ST_ADV, ST_SCAN_RD, ST_SCAN_EV, ST_NEXT
   } state_type;

   state_type          state_ff, state_in;
   logic [SW-1:0]      pos_ff [NUM_LEVELS];
   logic [SW-1:0]      pos_in [NUM_LEVELS];
   logic [POOL_SIZE-1:0] valid_ff, valid_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic [LW-1:0]      clv_ff, clv_in;
   logic [LW-1:0]      lv_ff, lv_in;
   logic [TW-1:0]      t_ff, t_in;
   logic [15:0]        task_ff, task_in;
   logic [15:0]        ident_ff, ident_in;
   logic [31:0]        msg_ff, msg_in;
   logic               from_tick_ff, from_tick_in;
   logic               flush_ff, flush_in;
   htw_pkg::kind_type  kind_ff, kind_in;
   logic               held_valid_ff, held_valid_in;
   logic [15:0]        held_task_ff, held_task_in;
   logic [15:0]        held_id_ff, held_id_in;
   logic [31:0]        held_msg_ff, held_msg_in;
   logic               rsp_valid_ff, rsp_valid_in;
   htw_pkg::kind_type  rsp_kind_ff, rsp_kind_in;
   logic [15:0]        rsp_task_ff, rsp_task_in;
   logic [15:0]        rsp_id_ff, rsp_id_in;
   logic [31:0]        rsp_msg_ff, rsp_msg_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               ram_we, ram_re;
   logic [WORD_W-1:0]  ram_wdata, ram_rdata;
   logic [LW-1:0]      rd_level;
   logic [SW-1:0]      rd_slot;
   logic [RW-1:0]      rd_rem;
   logic [15:0]        rd_task, rd_id;
   logic [31:0]        rd_msg;

   logic               out_free;
   logic [LW-1:0]      psel_idx;
   logic [SW-1:0]      psel;
   logic [5:0]         sh, shn;
   logic [TW:0]        span;
   logic [TW-1:0]      off, rem_mask;
   logic [SW-1:0]      new_slot;
   logic [RW-1:0]      new_rem;
   logic [40:0]        delay_ext;

   htw_ram #(.WIDTH(WORD_W), .DEPTH(POOL_SIZE)) u_pool (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (idx_ff),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (idx_ff),
      .rd_data (ram_rdata)
   );

   assign {rd_level, rd_slot, rd_rem, rd_task, rd_id, rd_msg} = ram_rdata;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign psel_idx = (state_ff == ST_PLACE) ? lv_ff : clv_ff;
   assign psel     = pos_ff[psel_idx];
   assign sh       = htw_pkg::unit_shift(int'(lv_ff));
   assign shn      = htw_pkg::unit_shift(int'(lv_ff) + 1);
   assign span     = (TW+1)'(1) << shn;
   assign off      = t_ff >> sh;
   assign rem_mask = (TW'(1) << sh) - TW'(1);
   assign new_slot = psel + off[SW-1:0];
   assign new_rem  = RW'(t_ff & rem_mask);
   assign ram_wdata = {lv_ff, new_slot, new_rem, task_ff, ident_ff, msg_ff};
   assign delay_ext = {5'd0, req_delay};

   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      valid_in      = valid_ff;
      idx_in        = idx_ff;
      clv_in        = clv_ff;
      lv_in         = lv_ff;
      t_in          = t_ff;
      task_in       = task_ff;
      ident_in      = ident_ff;
      msg_in        = msg_ff;
      from_tick_in  = from_tick_ff;
      flush_in      = flush_ff;
      kind_in       = kind_ff;
      held_valid_in = held_valid_ff;
      held_task_in  = held_task_ff;
      held_id_in    = held_id_ff;
      held_msg_in   = held_msg_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_task_in   = rsp_task_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_msg_in    = rsp_msg_ff;
      rsp_last_in   = rsp_last_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               task_in  = req_task_req;
               ident_in = req_msg_id;
               msg_in   = req_message;
               idx_in   = '0;
               if (req_operation == htw_pkg::OP_START) begin
                  t_in = TW'((delay_ext > FULL_SPAN) ? FULL_SPAN : delay_ext);
                  state_in = ST_FIND;
               end else begin
                  clv_in   = '0;
                  flush_in = 1'b0;
                  state_in = ST_ADV;
               end
            end
         end
         ST_FIND: begin
            if (!valid_ff[idx_ff]) begin
               lv_in        = '0;
               from_tick_in = 1'b0;
               state_in     = ST_PLACE;
            end else if (idx_ff == LAST_IDX) begin
               kind_in  = htw_pkg::KIND_FULL;
               state_in = ST_EMIT;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         ST_PLACE: begin
            if (lv_ff != TOP_LV && {1'b0, t_ff} > span) begin
               t_in  = t_ff + (TW'(psel) << sh);
               lv_in = lv_ff + LW'(1);
            end else begin
               ram_we           = 1'b1;
               valid_in[idx_ff] = 1'b1;
               if (from_tick_ff) begin
                  state_in = ST_NEXT;
               end else begin
                  kind_in  = htw_pkg::KIND_ACCEPTED;
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = kind_ff;
               rsp_task_in  = '0;
               rsp_id_in    = '0;
               rsp_msg_in   = '0;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_ADV: begin
            pos_in[clv_ff] = pos_ff[clv_ff] + SW'(1);
            idx_in         = '0;
            state_in       = ST_SCAN_RD;
         end
         ST_SCAN_RD: begin
            if (valid_ff[idx_ff]) begin
               ram_re   = 1'b1;
               state_in = ST_SCAN_EV;
            end else begin
               state_in = ST_NEXT;
            end
         end
         ST_SCAN_EV: begin
            if (rd_level != clv_ff || rd_slot != psel) begin
               state_in = ST_NEXT;
            end else if (rd_rem != '0) begin
               // cascade down from the remainder
               t_in         = TW'(rd_rem);
               lv_in        = '0;
               task_in      = rd_task;
               ident_in     = rd_id;
               msg_in       = rd_msg;
               from_tick_in = 1'b1;
               state_in     = ST_PLACE;
            end else if (!held_valid_ff || out_free) begin
               // the held expiry is known not to be last now
               if (held_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = htw_pkg::KIND_EXPIRED;
                  rsp_task_in  = held_task_ff;
                  rsp_id_in    = held_id_ff;
                  rsp_msg_in   = held_msg_ff;
                  rsp_last_in  = 1'b0;
               end
               held_valid_in    = 1'b1;
               held_task_in     = rd_task;
               held_id_in       = rd_id;
               held_msg_in      = rd_msg;
               valid_in[idx_ff] = 1'b0;
               state_in         = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (flush_ff) begin
               if (!held_valid_ff) begin
                  state_in = ST_IDLE;
               end else if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = htw_pkg::KIND_EXPIRED;
                  rsp_task_in   = held_task_ff;
                  rsp_id_in     = held_id_ff;
                  rsp_msg_in    = held_msg_ff;
                  rsp_last_in   = 1'b1;
                  held_valid_in = 1'b0;
                  state_in      = ST_IDLE;
               end
            end else if (idx_ff != LAST_IDX) begin
               idx_in   = idx_ff + IW'(1);
               state_in = ST_SCAN_RD;
            end else if (psel != '0 || clv_ff == TOP_LV) begin
               flush_in = 1'b1;
            end else begin
               clv_in   = clv_ff + LW'(1);
               state_in = ST_ADV;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         flush_ff      <= 1'b0;
         for (int i = 0; i < NUM_LEVELS; i++) begin
            pos_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         flush_ff      <= flush_in;
         pos_ff        <= pos_in;
      end
      idx_ff       <= idx_in;
      clv_ff       <= clv_in;
      lv_ff        <= lv_in;
      t_ff         <= t_in;
      task_ff      <= task_in;
      ident_ff     <= ident_in;
      msg_ff       <= msg_in;
      from_tick_ff <= from_tick_in;
      kind_ff      <= kind_in;
      held_task_ff <= held_task_in;
      held_id_ff   <= held_id_in;
      held_msg_ff  <= held_msg_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_task_ff  <= rsp_task_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_msg_ff   <= rsp_msg_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_stall           = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_kind            = rsp_kind_ff;
   assign rsp_expired_task    = rsp_task_ff;
   assign rsp_expired_id      = rsp_id_ff;
   assign rsp_expired_message = rsp_msg_ff;
   assign rsp_last            = rsp_last_ff;

   `HTW_ASSERT_SAME(a_idle_no_held, state_ff == ST_IDLE, !held_valid_ff, "held expiry left over")
   `HTW_ASSERT_SAME(a_status_last, rsp_valid_ff && rsp_kind_ff != htw_pkg::KIND_EXPIRED, rsp_last_ff, "start status without last")
   `HTW_ASSERT_SAME(a_scan_valid, state_ff == ST_SCAN_EV, valid_ff[idx_ff], "compare on a free entry")
   `HTW_ASSERT_NEXT(a_tick_step, state_ff == ST_ADV && clv_ff == '0, pos_ff[0] == SW'($past(pos_ff[0]) + SW'(1)), "level zero did not step")

endmodule

// ----- hw/rtl/htw_ram.sv -----
// generic single-port-write ram with registered read
module htw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- bench/tb_hierarchical_timing_wheel.sv -----
// self-checking testbench of the hierarchical timing wheel with its own wheel predictor
module tb_hierarchical_timing_wheel;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LEVELS = 6;
   localparam int SLOTS  = 64;
   localparam int POOL   = 64;
   localparam longint unsigned CAP       = 64'd1 << 40;
   localparam longint unsigned FULL_SPAN = 64'd1 << 36;
   localparam longint unsigned REM_MASK  = (64'd1 << 36) - 1;

   typedef struct {
      htw_pkg::kind_type kind;
      logic [15:0] task_h;
      logic [15:0] ident;
      logic [31:0] payload;
      logic        last;
   } outcome_type;

   typedef struct {
      bit          op;
      logic [35:0] delay;
      logic [15:0] task_h;
      logic [15:0] ident;
      logic [31:0] payload;
      bit          chk;
      htw_pkg::kind_type exp_kind;
   } row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_operation;
   logic [35:0] req_delay;
   logic [15:0] req_task_req;
   logic [15:0] req_msg_id;
   logic [31:0] req_message;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_kind;
   logic [15:0] rsp_expired_task;
   logic [15:0] rsp_expired_id;
   logic [31:0] rsp_expired_message;
   logic        rsp_last;

   hierarchical_timing_wheel dut (.*);

   // predictor state
   logic [5:0]      wheel_pos [LEVELS];
   bit              slot_used [POOL];
   int unsigned     tm_level  [POOL];
   logic [5:0]      tm_slot   [POOL];
   longint unsigned tm_rem    [POOL];
   logic [15:0]     tm_task   [POOL];
   logic [15:0]     tm_ident  [POOL];
   logic [31:0]     tm_payload[POOL];

   outcome_type pending_results[$];
   int errors = 0;
   int stall_pct = 0;
   int hold_req = 0;
   int hold_seen = 0;
   int hold_left = 0;
   bit gaps_on = 1;
   int burst_left = 0;
   bit need_low = 0;

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   function automatic longint unsigned widen(longint unsigned v);
      if (v <= CAP / SLOTS) return v * SLOTS;
      return CAP;
   endfunction

   function automatic void place_timer(int e, longint unsigned t);
      int unsigned lv;
      longint unsigned unit, span, off;
      lv = 0;
      unit = 1;
      span = SLOTS;
      while (lv + 1 < LEVELS && t > span) begin
         t += longint'(wheel_pos[lv]) * unit;
         unit = span;
         span = widen(span);
         lv++;
      end
      off = t / unit;
      t -= off * unit;
      tm_level[e] = lv;
      tm_slot[e] = 6'((wheel_pos[lv] + off % SLOTS) % SLOTS);
      tm_rem[e] = t & REM_MASK;
   endfunction

   function automatic void predict_start(logic [35:0] d, logic [15:0] th, logic [15:0] id,
                                         logic [31:0] msg);
      int e;
      longint unsigned dd;
      outcome_type r;
      e = 0;
      while (e < POOL && slot_used[e]) e++;
      r.task_h = 0; r.ident = 0; r.payload = 0; r.last = 1;
      if (e >= POOL) begin
         r.kind = htw_pkg::KIND_FULL;
      end else begin
         dd = d;
         if (dd > FULL_SPAN) dd = FULL_SPAN;
         slot_used[e] = 1;
         tm_task[e] = th;
         tm_ident[e] = id;
         tm_payload[e] = msg;
         place_timer(e, dd);
         r.kind = htw_pkg::KIND_ACCEPTED;
      end
      pending_results.push_back(r);
   endfunction

   function automatic void predict_tick();
      bit due [POOL];
      int n;
      outcome_type r;
      n = 0;
      for (int lv = 0; lv < LEVELS; lv++) begin
         wheel_pos[lv] = wheel_pos[lv] + 6'd1;
         for (int e = 0; e < POOL; e++)
            due[e] = slot_used[e] && tm_level[e] == lv && tm_slot[e] == wheel_pos[lv];
         for (int e = 0; e < POOL; e++) begin
            if (!due[e]) continue;
            if (tm_rem[e] != 0) begin
               place_timer(e, tm_rem[e]);
            end else begin
               r.kind = htw_pkg::KIND_EXPIRED;
               r.task_h = tm_task[e];
               r.ident = tm_ident[e];
               r.payload = tm_payload[e];
               r.last = 0;
               pending_results.push_back(r);
               slot_used[e] = 0;
               n++;
            end
         end
         if (wheel_pos[lv] != 0) break;
      end
      if (n > 0) pending_results[$].last = 1;
   endfunction

   // receiver: random stall pattern plus an occasional long hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_seen != hold_req) begin
         hold_seen <= hold_req;
         hold_left <= 400;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      outcome_type x;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result kind=%0d task=%h id=%h msg=%h last=%b",
                        rsp_kind, rsp_expired_task, rsp_expired_id,
                        rsp_expired_message, rsp_last);
         end else begin
            x = pending_results.pop_front();
            if (rsp_kind !== x.kind || rsp_expired_task !== x.task_h ||
                rsp_expired_id !== x.ident || rsp_expired_message !== x.payload ||
                rsp_last !== x.last) begin
               errors++;
               if (errors <= 10)
                  $display({"mismatch exp kind=%0d task=%h id=%h msg=%h last=%b, ",
                            "got kind=%0d task=%h id=%h msg=%h last=%b"},
                           x.kind, x.task_h, x.ident, x.payload, x.last, rsp_kind,
                           rsp_expired_task, rsp_expired_id, rsp_expired_message,
                           rsp_last);
            end
         end
      end
   end

   task automatic send(bit op, logic [35:0] d, logic [15:0] th, logic [15:0] id,
                       logic [31:0] msg);
      int gap;
      if (gaps_on && burst_left == 0) begin
         gap = $urandom_range(1, 8);
         burst_left = $urandom_range(1, 12);
         if (need_low) req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      if (burst_left > 0) burst_left--;
      req_valid <= 1'b1;
      req_operation <= op;
      req_delay <= d;
      req_task_req <= th;
      req_msg_id <= id;
      req_message <= msg;
      need_low = 1;
      do @(posedge clock); while (req_stall);
      if (op == htw_pkg::OP_START) predict_start(d, th, id, msg);
      else predict_tick();
   endtask

   task automatic drain();
      if (need_low) req_valid <= 1'b0;
      need_low = 0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   function automatic logic [35:0] rand_delay();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) return 36'($urandom_range(0, 130));
      if (pick < 80) return 36'($urandom_range(0, 5000));
      if (pick < 95) return 36'($urandom_range(130, 700));
      return {4'($urandom), 32'($urandom)};
   endfunction

   row_type dir_rows[$];

   initial begin
      row_type rw;
      bit op;
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = htw_pkg::OP_TICK;
      req_delay = '0;
      req_task_req = '0;
      req_msg_id = '0;
      req_message = '0;
      for (int i = 0; i < LEVELS; i++) wheel_pos[i] = 0;
      for (int i = 0; i < POOL; i++) slot_used[i] = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: tick with nothing due, delay edges at level borders, field extremes
      dir_rows = '{
         '{htw_pkg::OP_TICK,  36'd0,      16'h0, 16'h0, 32'h0, 0, htw_pkg::KIND_ACCEPTED},
         '{htw_pkg::OP_START, 36'd0,      16'h1, 16'h1, 32'h1, 1, htw_pkg::KIND_ACCEPTED},
         '{htw_pkg::OP_START, 36'd64,     16'h2, 16'h2, 32'h2, 1, htw_pkg::KIND_ACCEPTED},
         '{htw_pkg::OP_START, 36'd1,      16'h3, 16'h3, 32'h3, 1, htw_pkg::KIND_ACCEPTED},
         '{htw_pkg::OP_START, 36'd65,     16'h4, 16'h4, 32'h4, 1, htw_pkg::KIND_ACCEPTED},
         '{htw_pkg::OP_START, 36'd63,     16'h5, 16'h5, 32'h5, 1, htw_pkg::KIND_ACCEPTED},
         '{htw_pkg::OP_START, 36'd4096,   16'h6, 16'h6, 32'h6, 1, htw_pkg::KIND_ACCEPTED},
         '{htw_pkg::OP_START, 36'd4097,   16'h7, 16'h7, 32'h7, 1, htw_pkg::KIND_ACCEPTED},
         '{htw_pkg::OP_START, 36'd262145, 16'h8, 16'h8, 32'h8, 1, htw_pkg::KIND_ACCEPTED},
         '{htw_pkg::OP_START, 36'hF_FFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1,
           htw_pkg::KIND_ACCEPTED},
         '{htw_pkg::OP_START, 36'd0,      16'h0, 16'h0, 32'h0, 1, htw_pkg::KIND_ACCEPTED},
         '{htw_pkg::OP_START, 36'd2,      16'hA5A5, 16'h5A5A, 32'hDEAD_BEEF, 1,
           htw_pkg::KIND_ACCEPTED},
         '{htw_pkg::OP_TICK,  36'd0, 16'h0, 16'h0, 32'h0, 0, htw_pkg::KIND_ACCEPTED},
         '{htw_pkg::OP_TICK,  36'd0, 16'h0, 16'h0, 32'h0, 0, htw_pkg::KIND_ACCEPTED},
         '{htw_pkg::OP_TICK,  36'd0, 16'h0, 16'h0, 32'h0, 0, htw_pkg::KIND_ACCEPTED},
         '{htw_pkg::OP_TICK,  36'd0, 16'h0, 16'h0, 32'h0, 0, htw_pkg::KIND_ACCEPTED},
         '{htw_pkg::OP_START, 36'd1,      16'h9, 16'h9, 32'h9, 1, htw_pkg::KIND_ACCEPTED},
         '{htw_pkg::OP_TICK,  36'd0, 16'h0, 16'h0, 32'h0, 0, htw_pkg::KIND_ACCEPTED},
         '{htw_pkg::OP_TICK,  36'd0, 16'h0, 16'h0, 32'h0, 0, htw_pkg::KIND_ACCEPTED},
         '{htw_pkg::OP_TICK,  36'd0, 16'h0, 16'h0, 32'h0, 0, htw_pkg::KIND_ACCEPTED}
      };
      foreach (dir_rows[i]) begin
         rw = dir_rows[i];
         send(rw.op, rw.delay, rw.task_h, rw.ident, rw.payload);
         if (rw.chk && pending_results[$].kind != rw.exp_kind) begin
            errors++;
            if (errors <= 10) $display("directed row %0d: predicted kind differs", i);
         end
      end
      drain();

      // fill the pool past full while the receiver holds off
      stall_pct = 0;
      gaps_on = 0;
      hold_req++;
      for (int i = 0; i < 70; i++)
         send(htw_pkg::OP_START, 36'($urandom_range(0, 63)), 16'($urandom), 16'($urandom),
              $urandom);
      gaps_on = 1;
      stall_pct = 30;
      for (int i = 0; i < 70; i++) send(htw_pkg::OP_TICK, 36'($urandom), 16'($urandom),
                                        16'($urandom), $urandom);
      drain();

      // random mix
      for (int i = 0; i < 160; i++) begin
         if (i == 60) stall_pct = 70;
         if (i == 110) stall_pct = 0;
         op = ($urandom_range(0, 99) < 55) ? htw_pkg::OP_TICK : htw_pkg::OP_START;
         send(op, rand_delay(), 16'($urandom), 16'($urandom), $urandom);
      end
      drain();
      repeat (3000) @(posedge clock);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("tb_hierarchical_timing_wheel: done, clean");
      end else begin
         $display("tb_hierarchical_timing_wheel: done, errors");
      end
      $finish;
   end

   initial begin
      #9ms;
      $display("tb_hierarchical_timing_wheel: done, errors");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/htw_pkg.sv
hw/rtl/htw_ram.sv
hw/rtl/hierarchical_timing_wheel.sv
bench/tb_hierarchical_timing_wheel.sv
